### rtl/core/wpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants of the waypoint path densifier.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned SpacingW = 31;
  localparam logic [SpacingW-1:0] SpacingReset = 31'd327680;

  // restoring divider: one quotient bit per cycle over the coordinate width
  localparam int unsigned DivSteps = CoordW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     first_point;
  } wpd_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic                     is_interpolated;
    logic                     last_of_run;
  } wpd_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQS,
    ST_CMP,
    ST_SEARCH,
    ST_DIV,
    ST_EMIT,
    ST_LAST
  } wpd_state_e;

  typedef enum logic [1:0] {
    MUL_X,
    MUL_Y,
    MUL_S
  } wpd_mul_sel_e;

  typedef struct packed {
    logic         load_in;
    logic         mul_en;
    wpd_mul_sel_e mul_sel;
    logic         search_init;
    logic         search_step;
    logic         div_start;
    logic         emit_init;
    logic         emit_pt;
    logic         emit_last;
  } wpd_cmd_t;

  typedef struct packed {
    logic start_path;
    logic d2_gt;
    logic search_done;
    logic div_done;
    logic emit_end;
    logic out_free;
  } wpd_status_t;

endpackage
`default_nettype wire

### rtl/core/wpd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_div
// Two-lane restoring divider: unsigned 32-bit magnitudes by a small count.
// ----------------------------------------------------------------------------
module wpd_div
  import wpd_pkg::*;
#(
  parameter int unsigned NW = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [CoordW-1:0] a_i,
  input  wire logic [CoordW-1:0] b_i,
  input  wire logic [NW-1:0]     divisor_i,
  output logic                   done_o,
  output logic [CoordW-1:0]      qa_o,
  output logic [CoordW-1:0]      qb_o
);

  logic                busy_q, busy_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [NW-1:0]       div_q, div_d;
  logic [CoordW-1:0]   qa_q, qa_d, qb_q, qb_d;
  logic [NW-1:0]       ra_q, ra_d, rb_q, rb_d;
  logic [NW:0]         ra_sh, rb_sh;
  logic                ge_a, ge_b;

  assign ra_sh = {ra_q, qa_q[CoordW-1]};
  assign rb_sh = {rb_q, qb_q[CoordW-1]};
  assign ge_a  = ra_sh >= {1'b0, div_q};
  assign ge_b  = rb_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    div_d  = div_q;
    qa_d   = qa_q;
    qb_d   = qb_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      div_d  = divisor_i;
      qa_d   = a_i;
      qb_d   = b_i;
      ra_d   = '0;
      rb_d   = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so NW bits hold it
      ra_d  = ge_a ? NW'(ra_sh - {1'b0, div_q}) : NW'(ra_sh);
      rb_d  = ge_b ? NW'(rb_sh - {1'b0, div_q}) : NW'(rb_sh);
      qa_d  = {qa_q[CoordW-2:0], ge_a};
      qb_d  = {qb_q[CoordW-2:0], ge_b};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    qa_q  <= qa_d;
    qb_q  <= qb_d;
    ra_q  <= ra_d;
    rb_q  <= rb_d;
  end

  assign done_o = !busy_q;
  assign qa_o   = qa_q;
  assign qb_o   = qb_q;

endmodule
`default_nettype wire

### rtl/core/wpd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_dp
// Datapath: squared distance, segment count search, per-axis step and
// output point generation with the result register.
// ----------------------------------------------------------------------------
module wpd_dp
  import wpd_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [SpacingW-1:0] cfg_wdata_i,
  input  wire wpd_in_t             in_data_i,
  input  wire wpd_cmd_t            cmd_i,
  output wpd_status_t              status_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output wpd_out_t                 out_data_o
);

  localparam int unsigned KW = $clog2(MAX_SEGMENTS);
  localparam int unsigned NW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned QW = 2 * KW + 2 * CoordW;
  localparam int unsigned DW = 2 * CoordW + 1;

  logic [SpacingW-1:0]     spacing_q;
  logic signed [CoordW-1:0] prev_x_q, prev_y_q;
  logic                    have_prev_q;
  wpd_in_t                 pt_q;
  logic [CoordW:0]         dx_q, dy_q;
  logic [CoordW-1:0]       ax_q, ay_q;
  logic [2*CoordW-1:0]     prod_q;
  logic [DW-1:0]           d2_q;
  logic [2*CoordW-1:0]     s2_q;
  logic [QW-1:0]           q_q, t_q;
  logic [KW-1:0]           k_q, i_q;
  logic [CoordW-1:0]       step_x_q, step_y_q, cur_x_q, cur_y_q;
  logic                    out_valid_q;
  wpd_out_t                out_q;

  logic [CoordW:0]         dx_w, dy_w, adx_w, ady_w;
  logic [CoordW-1:0]       mul_a;
  logic [QW-1:0]           q_nx, d2_ext;
  logic                    pass;
  logic                    out_free;
  logic                    div_done;
  logic [CoordW-1:0]       qa, qb, step_x, step_y;
  logic [NW-1:0]           n_w;

  assign dx_w  = {in_data_i.point_x[CoordW-1], in_data_i.point_x}
               - {prev_x_q[CoordW-1], prev_x_q};
  assign dy_w  = {in_data_i.point_y[CoordW-1], in_data_i.point_y}
               - {prev_y_q[CoordW-1], prev_y_q};
  assign adx_w = dx_w[CoordW] ? (~dx_w + (CoordW+1)'(1)) : dx_w;
  assign ady_w = dy_w[CoordW] ? (~dy_w + (CoordW+1)'(1)) : dy_w;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_X:   mul_a = ax_q;
      MUL_Y:   mul_a = ay_q;
      MUL_S:   mul_a = {1'b0, spacing_q};
      default: mul_a = ax_q;
    endcase
  end

  // next candidate (k+1)^2 s^2 = k^2 s^2 + (2k+1) s^2
  assign d2_ext = QW'(d2_q);
  assign q_nx   = q_q + t_q;
  assign pass   = (q_nx <= d2_ext) && (k_q != KW'(MAX_SEGMENTS - 1));
  assign n_w    = NW'(k_q) + NW'(1);

  wpd_div #(
    .NW(NW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .a_i       (ax_q),
    .b_i       (ay_q),
    .divisor_i (n_w),
    .done_o    (div_done),
    .qa_o      (qa),
    .qb_o      (qb)
  );

  // truncation toward zero: divide magnitudes, then restore the sign
  assign step_x = dx_q[CoordW] ? (~qa + CoordW'(1)) : qa;
  assign step_y = dy_q[CoordW] ? (~qb + CoordW'(1)) : qb;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q   <= SpacingReset;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        spacing_q <= cfg_wdata_i;
      end
      if (cmd_i.emit_last) begin
        prev_x_q    <= pt_q.point_x;
        prev_y_q    <= pt_q.point_y;
        have_prev_q <= 1'b1;
      end
      if (cmd_i.emit_pt || cmd_i.emit_last) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pt_q <= in_data_i;
      dx_q <= dx_w;
      dy_q <= dy_w;
      ax_q <= adx_w[CoordW-1:0];
      ay_q <= ady_w[CoordW-1:0];
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_a;
      if (cmd_i.mul_sel == MUL_Y) begin
        d2_q <= DW'(prod_q);
      end else if (cmd_i.mul_sel == MUL_S) begin
        d2_q <= d2_q + DW'(prod_q);
      end
    end
    if (cmd_i.search_init) begin
      s2_q <= prod_q;
      q_q  <= QW'(prod_q);
      t_q  <= QW'(prod_q) + (QW'(prod_q) << 1);
      k_q  <= KW'(1);
    end else if (cmd_i.search_step && pass) begin
      q_q <= q_nx;
      t_q <= t_q + (QW'(s2_q) << 1);
      k_q <= k_q + KW'(1);
    end
    if (cmd_i.emit_init) begin
      step_x_q <= step_x;
      step_y_q <= step_y;
      cur_x_q  <= prev_x_q + step_x;
      cur_y_q  <= prev_y_q + step_y;
      i_q      <= KW'(1);
    end else if (cmd_i.emit_pt) begin
      cur_x_q <= cur_x_q + step_x_q;
      cur_y_q <= cur_y_q + step_y_q;
      i_q     <= i_q + KW'(1);
    end
    if (cmd_i.emit_pt) begin
      out_q.out_x           <= cur_x_q;
      out_q.out_y           <= cur_y_q;
      out_q.is_interpolated <= 1'b1;
      out_q.last_of_run     <= 1'b0;
    end else if (cmd_i.emit_last) begin
      out_q.out_x           <= pt_q.point_x;
      out_q.out_y           <= pt_q.point_y;
      out_q.is_interpolated <= 1'b0;
      out_q.last_of_run     <= 1'b1;
    end
  end

  assign status_o.start_path  = in_data_i.first_point || !have_prev_q;
  assign status_o.d2_gt       = d2_q > DW'(prod_q);
  assign status_o.search_done = !pass;
  assign status_o.div_done    = div_done;
  assign status_o.emit_end    = (i_q == k_q);
  assign status_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

### rtl/core/wpd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_ctrl
// Sequencer: input transfer, distance squares, count search, division and
// point emission.
// ----------------------------------------------------------------------------
module wpd_ctrl
  import wpd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire wpd_status_t status_i,
  output wpd_cmd_t         cmd_o
);

  wpd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_sel = MUL_X;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = status_i.start_path ? ST_LAST : ST_SQX;
        end
      end
      ST_SQX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_X;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_Y;
        state_d = ST_SQS;
      end
      ST_SQS: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_S;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.search_init = 1'b1;
        state_d = status_i.d2_gt ? ST_SEARCH : ST_LAST;
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        if (status_i.search_done) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.emit_init = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_pt = 1'b1;
          if (status_i.emit_end) begin
            state_d = ST_LAST;
          end
        end
      end
      ST_LAST: begin
        if (status_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/waypoint_path_densifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_path_densifier
// Inserts evenly spaced points between consecutive waypoints of a path.
// ----------------------------------------------------------------------------
// Sequence: a path start sends the waypoint alone; a gap within spacing adds
//   3 squares and the compare; a run of n segments adds the count search, the
//   division and n-1 inserted points ahead of the waypoint.
// Throughput: one waypoint at a time; the next is taken at the edge where the
//   last result can first transfer, output stalls on inserted points add on.
// Reset: asynchronous; spacing returns to 5.0 cells, no previous waypoint.
module waypoint_path_densifier
  import wpd_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [SpacingW-1:0] cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire wpd_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output wpd_out_t                 out_data_o
);

  wpd_cmd_t    cmd;
  wpd_status_t status;

  wpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wpd_dp #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### rtl/core/wpd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_checker
// Port-level checks of the densifier, bound to the top level.
// ----------------------------------------------------------------------------
module wpd_checker
  import wpd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire wpd_out_t            out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // after an input transfer the block is busy until its run is done
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a run is in progress");

  // the waypoint closes its run, inserted points never do
  a_last_is_waypoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_interpolated != out_data_o.last_of_run))
    else $error("run flags inconsistent");

  // when idle, only the closing waypoint of the previous run can be pending
  a_idle_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && out_valid_o |-> out_data_o.last_of_run)
    else $error("inserted point pending while idle");

endmodule

bind waypoint_path_densifier wpd_checker u_wpd_checker (.*);
`default_nettype wire

### verif/waypoint_path_densifier_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_path_densifier_tb
// Self-checking bench for the waypoint densifier: a cycle-free predictor
// computes the expected run of points for each accepted waypoint, and every
// output transfer is compared field by field. Directed moves, spacing
// extremes and random paths are run with random idling on both sides.
// ----------------------------------------------------------------------------
module waypoint_path_densifier_tb;
  import wpd_pkg::*;

  localparam int unsigned MaxSegments = 32;
  localparam int unsigned IdleLimit   = 4000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [SpacingW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  wpd_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  wpd_out_t            out_data_o;

  // predictor state
  logic signed [CoordW-1:0] prev_x;
  logic signed [CoordW-1:0] prev_y;
  logic                     have_prev;
  logic [SpacingW-1:0]      spacing;

  wpd_out_t    pending_pts[$];
  int unsigned error_count = 0;
  int unsigned out_hold    = 0;
  int unsigned idle_cycles = 0;
  logic        no_idle     = 1'b0;

  always #5 clk_i = ~clk_i;

  waypoint_path_densifier #(
    .MAX_SEGMENTS(MaxSegments)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Expected run for one accepted waypoint: interpolated points, then the
  // waypoint itself. Segment count is found with exact squared compares.
  task automatic predict_run(input wpd_in_t pt);
    longint       dx, dy, stx, sty, n, i;
    int           k;
    logic [63:0]  ax, ay;
    logic [127:0] dist_sq, gap_sq, seg_len, seg_sq;
    logic         searching;
    wpd_out_t     res;
    if (!pt.first_point && have_prev) begin
      dx = longint'(pt.point_x) - longint'(prev_x);
      dy = longint'(pt.point_y) - longint'(prev_y);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      dist_sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
      gap_sq  = 128'(spacing) * 128'(spacing);
      if (dist_sq > gap_sq) begin
        n = 1;
        searching = 1'b1;
        for (k = 1; k < MaxSegments && searching; k++) begin
          seg_len = 128'(k) * 128'(spacing);
          seg_sq  = seg_len * seg_len;
          if (seg_sq > dist_sq) searching = 1'b0;
          else n = k + 1;
        end
        // step truncates toward zero
        stx = dx / n;
        sty = dy / n;
        for (i = 1; i < n; i++) begin
          res.out_x           = 32'(longint'(prev_x) + i * stx);
          res.out_y           = 32'(longint'(prev_y) + i * sty);
          res.is_interpolated = 1'b1;
          res.last_of_run     = 1'b0;
          pending_pts = {pending_pts, res};
        end
      end
    end
    res.out_x           = pt.point_x;
    res.out_y           = pt.point_y;
    res.is_interpolated = 1'b0;
    res.last_of_run     = 1'b1;
    pending_pts = {pending_pts, res};
    prev_x    = pt.point_x;
    prev_y    = pt.point_y;
    have_prev = 1'b1;
  endtask

  task automatic check_result(input wpd_out_t got);
    wpd_out_t want;
    if (pending_pts.size() == 0) begin
      $error("unexpected point x=%0d y=%0d", got.out_x, got.out_y);
      error_count++;
    end else begin
      want = pending_pts.pop_front();
      if (got.out_x !== want.out_x) begin
        $error("out_x: expected %0d, got %0d", want.out_x, got.out_x);
        error_count++;
      end
      if (got.out_y !== want.out_y) begin
        $error("out_y: expected %0d, got %0d", want.out_y, got.out_y);
        error_count++;
      end
      if (got.is_interpolated !== want.is_interpolated) begin
        $error("is_interpolated: expected %0b, got %0b", want.is_interpolated,
               got.is_interpolated);
        error_count++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
        error_count++;
      end
    end
  endtask

  // Output side: after each transfer, stall for a drawn number of cycles in
  // which a point is offered, so the first point of a run gets stalled too.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      check_result(out_data_o);
      out_hold = no_idle ? 0 : $urandom_range(0, 4);
      out_stall_i <= (out_hold != 0);
    end else if (out_valid_o && out_hold != 0) begin
      out_hold--;
      out_stall_i <= (out_hold != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Valid is left high after a transfer; the next call either keeps it high
  // or drops it for its gap, so valid gets one update per step.
  task automatic send_waypoint(input wpd_in_t pt);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pt;
    do @(posedge clk_i); while (in_stall_o);
    predict_run(pt);
  endtask

  task automatic send_xy(input logic signed [CoordW-1:0] x,
                         input logic signed [CoordW-1:0] y, input logic first);
    wpd_in_t pt;
    pt.point_x     = x;
    pt.point_y     = y;
    pt.first_point = first;
    send_waypoint(pt);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_spacing(input logic [SpacingW-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    spacing = value;
  endtask

  // Random move away from a coordinate, scaled to the current spacing.
  function automatic logic signed [CoordW-1:0] offset_coord(
      input logic signed [CoordW-1:0] from);
    longint base, reach, v;
    base  = (spacing == 0) ? 65536 : longint'(spacing);
    reach = base * $urandom_range(0, 48) / 8 + $urandom_range(0, 255);
    v = longint'(from) + ($urandom_range(0, 1) ? reach : -reach);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 32'(v);
  endfunction

  task automatic test_directed_moves();
    send_xy(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);  // no previous point yet
    send_xy(0, 0, 1'b1);
    send_xy(0, 0, 1'b0);                          // repeated point
    send_xy(196608, 262144, 1'b0);                // 3-4-5: exactly one spacing
    send_xy(524289, 262144, 1'b0);                // just over one spacing
    send_xy(-458751, 262144, 1'b0);               // exactly three spacings back
    send_xy(-1458752, 1262143, 1'b0);             // odd deltas, truncated steps
    send_xy(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_xy(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);  // full diagonal, saturates
    send_xy(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_xy(32'h7FFF_FFFF, 0, 1'b1);
    send_xy(32'h7EDC_BA98, 0, 1'b0);
    send_xy(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    send_xy(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_xy(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
  endtask

  task automatic test_spacing_extremes();
    write_spacing(31'd1);
    send_xy(0, 0, 1'b1);
    send_xy(1, 0, 1'b0);
    send_xy(3, 0, 1'b0);
    send_xy(8, 3, 1'b0);
    send_xy(32'h8000_0000, 3, 1'b0);
    write_spacing(31'h7FFF_FFFF);
    send_xy(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_xy(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_xy(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    // zero spacing: any move saturates, a zero move does not split
    write_spacing(31'd0);
    send_xy(100, 100, 1'b1);
    send_xy(100, 100, 1'b0);
    send_xy(101, 100, 1'b0);
    send_xy(-1000, 5000, 1'b0);
  endtask

  // Mostly well-formed paths with random moves, some stray items in between.
  task automatic test_random_paths(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    wpd_in_t     pt;
    sent = 0;
    while (sent < count) begin
      pt.point_x = $urandom;
      pt.point_y = $urandom;
      if ($urandom_range(0, 7) == 0) begin
        pt.first_point = 1'($urandom_range(0, 1));
        send_waypoint(pt);
        sent++;
      end else begin
        pt.first_point = 1'b1;
        send_waypoint(pt);
        sent++;
        len = $urandom_range(1, 8);
        repeat (len) begin
          pt.point_x     = offset_coord(pt.point_x);
          pt.point_y     = offset_coord(pt.point_y);
          pt.first_point = 1'b0;
          send_waypoint(pt);
          sent++;
        end
      end
    end
  endtask

  task automatic test_back_to_back();
    write_spacing(SpacingW'($urandom_range(32'h0001_0000, 32'h0010_0000)));
    no_idle = 1'b1;
    test_random_paths(30);
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_spacings();
    int                  phase;
    logic [SpacingW-1:0] value;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: value = SpacingW'($urandom_range(1, 32'h0004_0000));
        1: value = SpacingW'($urandom_range(32'h0001_0000, 32'h0040_0000));
        2: value = SpacingW'($urandom);
        default: value = SpacingReset;
      endcase
      write_spacing(value);
      test_random_paths(35);
    end
  endtask

  initial begin
    prev_x    = '0;
    prev_y    = '0;
    have_prev = 1'b0;
    spacing   = SpacingReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_moves();
    test_spacing_extremes();
    test_back_to_back();
    test_random_spacings();

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
rtl/core/wpd_pkg.sv
rtl/core/wpd_div.sv
rtl/core/wpd_dp.sv
rtl/core/wpd_ctrl.sv
rtl/core/waypoint_path_densifier.sv
rtl/core/wpd_checker.sv
verif/waypoint_path_densifier_tb.sv
